// ===== src/y2r_pkg.sv =====
// ----------------------------------------------------------------------------
// y2r_pkg
// shared sizes, register indexes, command types and helpers for the
// planar yuv 4:2:0 to rgb565 converter with optional rotation
// ----------------------------------------------------------------------------
package y2r_pkg;

	// largest frame the stores hold
	localparam int MAX_WIDTH  = 512;
	localparam int MAX_HEIGHT = 512;

	// coordinate, size and address widths
	localparam int MAX_SIDE  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
	localparam int COORD_W   = $clog2(MAX_SIDE);
	localparam int SIZE_W    = $clog2(MAX_SIDE + 1);
	localparam int LUMA_DEPTH   = MAX_WIDTH * MAX_HEIGHT;
	localparam int CHROMA_DEPTH = LUMA_DEPTH / 4;
	localparam int LUMA_AW   = $clog2(LUMA_DEPTH);
	localparam int CHROMA_AW = $clog2(CHROMA_DEPTH);

	// configuration port
	localparam int CFG_W     = 10;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROTATE = 2'd2;
	localparam logic [CFG_W-1:0] WIDTH_RESET  = 10'd320;
	localparam logic [CFG_W-1:0] HEIGHT_RESET = 10'd240;

	// operation codes
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_FETCH = 1'b1;

	// command queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	// color conversion coefficients, 8 fractional bits
	localparam int C_RV  = 359;
	localparam int C_GU  = 88;
	localparam int C_GV  = 183;
	localparam int C_BU  = 454;
	localparam int C_MID = 128;
	localparam int SUM_W = 19;

	typedef enum logic [1:0] {
		PLANE_Y,
		PLANE_U,
		PLANE_V
	} plane_t;

	typedef enum logic [1:0] {
		CMD_LOAD,
		CMD_FETCH,
		CMD_BLANK
	} cmd_kind_t;

	// effective frame geometry
	typedef struct packed {
		logic [SIZE_W-1:0] w;
		logic [SIZE_W-1:0] h;
		logic              rotate;
	} geom_t;

	// one request as classified by the front
	typedef struct packed {
		cmd_kind_t          kind;
		plane_t             plane;
		logic [7:0]         sample;
		logic [LUMA_AW-1:0] addr;
		logic [COORD_W-1:0] y_row;
		logic [COORD_W-1:0] y_col;
		logic [COORD_W-1:0] c_row;
		logic [COORD_W-1:0] c_col;
		logic               last;
	} cmd_t;

	// clear low bit, raise to 2, cap at limit
	function automatic logic [SIZE_W-1:0] fit_size(input logic [CFG_W-1:0] value,
		input int limit);
		int unsigned v;
		v = 32'(value) & ~32'd1;
		if (v < 32'd2) v = 32'd2;
		if (v > 32'(limit)) v = 32'(limit);
		return SIZE_W'(v);
	endfunction

endpackage

// ===== src/y2r_front.sv =====
// ----------------------------------------------------------------------------
// y2r_front
// classifies requests, keeps load and output positions, builds commands
// ----------------------------------------------------------------------------
module y2r_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic                 operation,
	input  logic [7:0]           sample,
	input  logic                 restart,
	input  y2r_pkg::geom_t       geom,
	output logic                 push,
	output y2r_pkg::cmd_t        cmd
);

	logic [y2r_pkg::COORD_W-1:0] load_col_q, load_row_q;
	logic [y2r_pkg::LUMA_AW-1:0] load_addr_q;
	y2r_pkg::plane_t             plane_q;
	logic                        frame_loaded_q;
	logic [y2r_pkg::COORD_W-1:0] out_line_q, out_col_q;

	logic [y2r_pkg::SIZE_W-1:0] col_lim, row_lim, ow, oh;
	logic [y2r_pkg::SIZE_W-1:0] col_nx, row_nx, oc_nx, ol_nx;
	logic                       col_end, row_end, oc_end, ol_end;
	logic [y2r_pkg::SIZE_W-1:0] rot_y_row, rot_c_row;

	// plane size limits for the load position
	assign col_lim = (plane_q == y2r_pkg::PLANE_Y) ? geom.w : (geom.w >> 1);
	assign row_lim = (plane_q == y2r_pkg::PLANE_Y) ? geom.h : (geom.h >> 1);
	assign col_nx  = y2r_pkg::SIZE_W'(load_col_q) + 1'b1;
	assign row_nx  = y2r_pkg::SIZE_W'(load_row_q) + 1'b1;
	assign col_end = (col_nx == col_lim);
	assign row_end = (row_nx == row_lim);

	// output frame size
	assign ow     = geom.rotate ? geom.h : geom.w;
	assign oh     = geom.rotate ? geom.w : geom.h;
	assign oc_nx  = y2r_pkg::SIZE_W'(out_col_q) + 1'b1;
	assign ol_nx  = y2r_pkg::SIZE_W'(out_line_q) + 1'b1;
	assign oc_end = (oc_nx >= ow);
	assign ol_end = (ol_nx >= oh);

	// clockwise turn: source row counts down with the output column
	assign rot_y_row = geom.h - 1'b1 - y2r_pkg::SIZE_W'(out_col_q);
	assign rot_c_row = (geom.h >> 1) - 1'b1 - y2r_pkg::SIZE_W'(out_col_q >> 1);

	assign push = accept;

	always_comb begin
		cmd        = '0;
		cmd.sample = sample;
		cmd.plane  = plane_q;
		cmd.addr   = load_addr_q;
		if (operation == y2r_pkg::OP_LOAD) begin
			cmd.kind = y2r_pkg::CMD_LOAD;
		end else if (!frame_loaded_q) begin
			cmd.kind = y2r_pkg::CMD_BLANK;
		end else begin
			cmd.kind = y2r_pkg::CMD_FETCH;
			cmd.last = oc_end && ol_end;
			if (geom.rotate) begin
				cmd.y_row = y2r_pkg::COORD_W'(rot_y_row);
				cmd.y_col = out_line_q;
				cmd.c_row = y2r_pkg::COORD_W'(rot_c_row);
				cmd.c_col = out_line_q >> 1;
			end else begin
				cmd.y_row = out_line_q;
				cmd.y_col = out_col_q;
				cmd.c_row = out_line_q >> 1;
				cmd.c_col = out_col_q >> 1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_col_q     <= '0;
			load_row_q     <= '0;
			load_addr_q    <= '0;
			plane_q        <= y2r_pkg::PLANE_Y;
			frame_loaded_q <= 1'b0;
			out_line_q     <= '0;
			out_col_q      <= '0;
		end else if (restart) begin
			load_col_q     <= '0;
			load_row_q     <= '0;
			load_addr_q    <= '0;
			plane_q        <= y2r_pkg::PLANE_Y;
			frame_loaded_q <= 1'b0;
			out_line_q     <= '0;
			out_col_q      <= '0;
		end else if (accept && operation == y2r_pkg::OP_LOAD) begin
			frame_loaded_q <= 1'b0;
			if (!col_end) begin
				load_col_q  <= y2r_pkg::COORD_W'(col_nx);
				load_addr_q <= load_addr_q + 1'b1;
			end else if (!row_end) begin
				load_col_q  <= '0;
				load_row_q  <= y2r_pkg::COORD_W'(row_nx);
				load_addr_q <= load_addr_q + 1'b1;
			end else begin
				load_col_q  <= '0;
				load_row_q  <= '0;
				load_addr_q <= '0;
				unique case (plane_q)
					y2r_pkg::PLANE_Y: plane_q <= y2r_pkg::PLANE_U;
					y2r_pkg::PLANE_U: plane_q <= y2r_pkg::PLANE_V;
					default: begin
						// last red-difference sample: frame complete
						plane_q        <= y2r_pkg::PLANE_Y;
						frame_loaded_q <= 1'b1;
						out_line_q     <= '0;
						out_col_q      <= '0;
					end
				endcase
			end
		end else if (accept && frame_loaded_q) begin
			if (oc_end) begin
				out_col_q  <= '0;
				out_line_q <= ol_end ? '0 : y2r_pkg::COORD_W'(ol_nx);
			end else begin
				out_col_q <= y2r_pkg::COORD_W'(oc_nx);
			end
		end
	end

endmodule

// ===== src/y2r_queue.sv =====
// ----------------------------------------------------------------------------
// y2r_queue
// short command fifo between front and back
// ----------------------------------------------------------------------------
module y2r_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  y2r_pkg::cmd_t push_cmd,
	input  logic          pop,
	output logic          not_empty,
	output logic          full,
	output y2r_pkg::cmd_t head
);

	y2r_pkg::cmd_t                 entry_q [y2r_pkg::QUEUE_DEPTH];
	logic [y2r_pkg::QUEUE_AW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [y2r_pkg::QUEUE_AW:0]    count_q;

	assign not_empty = (count_q != '0);
	assign full      = (count_q == (y2r_pkg::QUEUE_AW+1)'(y2r_pkg::QUEUE_DEPTH));
	assign head      = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== src/y2r_back.sv =====
// ----------------------------------------------------------------------------
// y2r_back
// address generation, frame stores, color conversion and result register
// ----------------------------------------------------------------------------
module y2r_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  y2r_pkg::cmd_t  cmd,
	input  y2r_pkg::geom_t geom,
	output logic           pop,
	output logic           done,
	output logic [15:0]    pixel,
	output logic           last_pixel,
	output logic           frame_ready
);

	localparam int PROD_W = y2r_pkg::COORD_W + y2r_pkg::SIZE_W;
	localparam int SW     = y2r_pkg::SUM_W;

	// frame stores
	logic [7:0] luma_mem [y2r_pkg::LUMA_DEPTH];
	logic [7:0] blue_mem [y2r_pkg::CHROMA_DEPTH];
	logic [7:0] red_mem  [y2r_pkg::CHROMA_DEPTH];

	// stage 1: addresses
	logic                          valid_s1, last_s1;
	y2r_pkg::cmd_kind_t            kind_s1;
	y2r_pkg::plane_t               plane_s1;
	logic [7:0]                    sample_s1;
	logic [y2r_pkg::LUMA_AW-1:0]   luma_addr_s1;
	logic [y2r_pkg::CHROMA_AW-1:0] chroma_addr_s1;

	// stage 2: store read data
	logic               valid_s2, last_s2;
	y2r_pkg::cmd_kind_t kind_s2;
	logic [7:0]         y_s2, u_s2, v_s2;

	// stage 3: coefficient products
	logic                 valid_s3, last_s3;
	y2r_pkg::cmd_kind_t   kind_s3;
	logic signed [SW-1:0] y256_s3, prod_rv_s3, prod_gu_s3, prod_gv_s3, prod_bu_s3;

	logic [PROD_W-1:0]         prod_y, prod_c;
	logic [y2r_pkg::SIZE_W-1:0] w_half;
	logic signed [8:0]         d_val, e_val;
	logic signed [SW-1:0]      sum_r, sum_g, sum_b;
	logic [7:0]                r_ch, g_ch, b_ch;

	function automatic logic [7:0] clamp_channel(input logic signed [SW-1:0] s);
		if (s[SW-1]) return 8'd0;
		if (|s[SW-2:16]) return 8'hFF;
		return s[15:8];
	endfunction

	assign pop    = cmd_valid;
	assign w_half = geom.w >> 1;
	assign prod_y = cmd.y_row * geom.w;
	assign prod_c = cmd.c_row * w_half;

	always_ff @(posedge clk) begin
		kind_s1   <= cmd.kind;
		plane_s1  <= cmd.plane;
		sample_s1 <= cmd.sample;
		last_s1   <= cmd.last;
		if (cmd.kind == y2r_pkg::CMD_LOAD) begin
			luma_addr_s1   <= cmd.addr;
			chroma_addr_s1 <= y2r_pkg::CHROMA_AW'(cmd.addr);
		end else begin
			luma_addr_s1   <= y2r_pkg::LUMA_AW'(prod_y + PROD_W'(cmd.y_col));
			chroma_addr_s1 <= y2r_pkg::CHROMA_AW'(prod_c + PROD_W'(cmd.c_col));
		end
	end

	// stores: write on load, registered read on fetch
	always_ff @(posedge clk) begin
		if (valid_s1 && kind_s1 == y2r_pkg::CMD_LOAD && plane_s1 == y2r_pkg::PLANE_Y) begin
			luma_mem[luma_addr_s1] <= sample_s1;
		end
		if (valid_s1 && kind_s1 == y2r_pkg::CMD_FETCH) begin
			y_s2 <= luma_mem[luma_addr_s1];
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && kind_s1 == y2r_pkg::CMD_LOAD && plane_s1 == y2r_pkg::PLANE_U) begin
			blue_mem[chroma_addr_s1] <= sample_s1;
		end
		if (valid_s1 && kind_s1 == y2r_pkg::CMD_FETCH) begin
			u_s2 <= blue_mem[chroma_addr_s1];
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && kind_s1 == y2r_pkg::CMD_LOAD && plane_s1 == y2r_pkg::PLANE_V) begin
			red_mem[chroma_addr_s1] <= sample_s1;
		end
		if (valid_s1 && kind_s1 == y2r_pkg::CMD_FETCH) begin
			v_s2 <= red_mem[chroma_addr_s1];
		end
	end

	always_ff @(posedge clk) begin
		kind_s2 <= kind_s1;
		last_s2 <= last_s1;
	end

	// stage 3: centered chroma times coefficients
	assign d_val = $signed({1'b0, u_s2}) - 9'sd128;
	assign e_val = $signed({1'b0, v_s2}) - 9'sd128;

	always_ff @(posedge clk) begin
		kind_s3    <= kind_s2;
		last_s3    <= last_s2;
		y256_s3    <= $signed({{(SW-16){1'b0}}, y_s2, 8'd0});
		prod_rv_s3 <= SW'(e_val) * SW'(y2r_pkg::C_RV);
		prod_gu_s3 <= SW'(d_val) * SW'(y2r_pkg::C_GU);
		prod_gv_s3 <= SW'(e_val) * SW'(y2r_pkg::C_GV);
		prod_bu_s3 <= SW'(d_val) * SW'(y2r_pkg::C_BU);
	end

	// stage 4: sums, clamp, pack
	assign sum_r = y256_s3 + prod_rv_s3;
	assign sum_g = y256_s3 - prod_gu_s3 - prod_gv_s3;
	assign sum_b = y256_s3 + prod_bu_s3;
	assign r_ch  = clamp_channel(sum_r);
	assign g_ch  = clamp_channel(sum_g);
	assign b_ch  = clamp_channel(sum_b);

	always_ff @(posedge clk) begin
		if (kind_s3 == y2r_pkg::CMD_FETCH) begin
			pixel <= {r_ch[7:3], g_ch[7:2], b_ch[7:3]};
		end else begin
			pixel <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			done        <= 1'b0;
			last_pixel  <= 1'b0;
			frame_ready <= 1'b0;
		end else begin
			valid_s1    <= cmd_valid;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			done        <= valid_s3 && (kind_s3 != y2r_pkg::CMD_LOAD);
			frame_ready <= valid_s3 && (kind_s3 == y2r_pkg::CMD_FETCH);
			last_pixel  <= valid_s3 && (kind_s3 == y2r_pkg::CMD_FETCH) && last_s3;
		end
	end

endmodule

// ===== src/yuv420_to_rgb565_rotator.sv =====
// ----------------------------------------------------------------------------
// yuv420_to_rgb565_rotator
// loads a planar 4:2:0 frame sample by sample and returns it as rgb565
// pixels in raster order, optionally turned 90 degrees clockwise
// ----------------------------------------------------------------------------
//
// channel    | direction | handshake                 | payload
// -----------+-----------+---------------------------+-----------------------------
// request    | in        | start high, busy low      | operation, sample
// result     | out       | done high for one cycle   | pixel, last_pixel, frame_ready
// config     | in        | cfg_write high            | cfg_index, cfg_data
//
// one request per cycle is taken; a fetch shows its result after the queue and the
// back's address, store-read, product and result registers, a load gives no result
// the back takes a command from the queue every cycle, so the queue never
// holds more than one command and busy stays low
// reset clears positions and config to 320 x 240, no rotation; the frame
// stores are not cleared and hold nothing valid until a frame is loaded
// the receiver cannot stall: done is a one-cycle strobe
//
module yuv420_to_rgb565_rotator (
	input  logic                            clk,
	input  logic                            arst_n,
	// request channel
	input  logic                            start,
	output logic                            busy,
	input  logic                            operation,
	input  logic [7:0]                      sample,
	// configuration write port
	input  logic                            cfg_write,
	input  logic [y2r_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [y2r_pkg::CFG_W-1:0]       cfg_data,
	// result channel
	output logic                            done,
	output logic [15:0]                     pixel,
	output logic                            last_pixel,
	output logic                            frame_ready
);

	// configuration registers
	logic [y2r_pkg::CFG_W-1:0] width_q, height_q;
	logic                      rotate_q;
	logic                      restart;

	y2r_pkg::geom_t geom;
	y2r_pkg::cmd_t  front_cmd, head_cmd;
	logic           accept, push, pop, not_empty, full;

	// any write to a known register restarts the frame
	assign restart = cfg_write && (cfg_index == y2r_pkg::REG_WIDTH ||
		cfg_index == y2r_pkg::REG_HEIGHT || cfg_index == y2r_pkg::REG_ROTATE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= y2r_pkg::WIDTH_RESET;
			height_q <= y2r_pkg::HEIGHT_RESET;
			rotate_q <= 1'b0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				y2r_pkg::REG_WIDTH:  width_q  <= cfg_data;
				y2r_pkg::REG_HEIGHT: height_q <= cfg_data;
				y2r_pkg::REG_ROTATE: rotate_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// effective size: even, at least 2, capped at the store size
	assign geom.w      = y2r_pkg::fit_size(width_q, y2r_pkg::MAX_WIDTH);
	assign geom.h      = y2r_pkg::fit_size(height_q, y2r_pkg::MAX_HEIGHT);
	assign geom.rotate = rotate_q;

	assign busy   = full;
	assign accept = start && !busy;

	// front: classify the request and step the load / output positions
	y2r_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.operation (operation),
		.sample    (sample),
		.restart   (restart),
		.geom      (geom),
		.push      (push),
		.cmd       (front_cmd)
	);

	// queue: lets front and back run independently
	y2r_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (front_cmd),
		.pop       (pop),
		.not_empty (not_empty),
		.full      (full),
		.head      (head_cmd)
	);

	// back: store access and color conversion
	y2r_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (not_empty),
		.cmd         (head_cmd),
		.geom        (geom),
		.pop         (pop),
		.done        (done),
		.pixel       (pixel),
		.last_pixel  (last_pixel),
		.frame_ready (frame_ready)
	);

endmodule

// ===== src/y2r_checker.sv =====
// ----------------------------------------------------------------------------
// y2r_checker
// port-level checks on request to result timing and result fields
// ----------------------------------------------------------------------------
module y2r_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          operation,
	input logic                          cfg_write,
	input logic [y2r_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic                          done,
	input logic [15:0]                   pixel,
	input logic                          last_pixel,
	input logic                          frame_ready
);

	logic fetch_acc;
	logic restart_wr;

	assign fetch_acc  = arst_n && start && !busy && (operation == y2r_pkg::OP_FETCH);
	assign restart_wr = cfg_write && (cfg_index == y2r_pkg::REG_WIDTH ||
		cfg_index == y2r_pkg::REG_HEIGHT || cfg_index == y2r_pkg::REG_ROTATE);

	// every fetch gives exactly one result
	a_fetch_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		fetch_acc |-> ##5 done)
		else $error("fetch request produced no result");

	a_result_from_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(fetch_acc, 5))
		else $error("result without a matching fetch");

	// a result without a loaded frame is all zero
	a_blank_result: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !frame_ready) |-> (pixel == 16'd0 && !last_pixel))
		else $error("not-ready result carries data");

	// a fetch right after a restart cannot see a loaded frame
	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		($past(restart_wr) && fetch_acc) |-> ##5 !frame_ready)
		else $error("frame still ready after config restart");

endmodule

bind yuv420_to_rgb565_rotator y2r_checker u_y2r_checker (.*);
